// ----- rtl/core/printer_link_frame_deframer_defines.svh -----
// assertion helpers shared by the deframer modules
`ifndef PRINTER_LINK_FRAME_DEFRAMER_DEFINES_SVH
`define PRINTER_LINK_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PLFD_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PLFD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/plfd_pkg.sv -----
`default_nettype none

package plfd_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int QUEUE_DEPTH = 2;

    // checksum bytes plus the end byte
    localparam logic [15:0] TRAILER_BYTES = 16'd5;

    localparam logic [7:0]  START_RESET  = 8'd2;
    localparam logic [7:0]  END_RESET    = 8'd3;
    localparam logic [7:0]  PLAIN_RESET  = 8'd0;
    localparam logic [7:0]  PACKED_RESET = 8'd1;
    localparam logic [15:0] LIMIT_RESET  = 16'd2048;

    // register index within the configuration space
    localparam logic [2:0] REG_START_MARKER = 3'd0;
    localparam logic [2:0] REG_END_MARKER   = 3'd1;
    localparam logic [2:0] REG_TYPE_PLAIN   = 3'd2;
    localparam logic [2:0] REG_TYPE_PACKED  = 3'd3;
    localparam logic [2:0] REG_LENGTH_LIMIT = 3'd4;

    localparam logic EV_PAYLOAD = 1'b0;
    localparam logic EV_FRAME   = 1'b1;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  end_marker;
        logic [7:0]  type_plain;
        logic [7:0]  type_packed;
        logic [15:0] length_limit;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [15:0] offset;
        logic [7:0]  ftype;
        logic [7:0]  findex;
        logic [15:0] flength;
    } rec_t;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_TYPE    = 7'b0000010,
        ST_INDEX   = 7'b0000100,
        ST_LEN_LO  = 7'b0001000,
        ST_LEN_HI  = 7'b0010000,
        ST_PAYLOAD = 7'b0100000,
        ST_TRAILER = 7'b1000000
    } fstate_t;

endpackage

`default_nettype wire

// ----- rtl/core/plfd_regs.sv -----
`default_nettype none

module plfd_regs
    import plfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker <= START_RESET;
            cfg_reg.end_marker   <= END_RESET;
            cfg_reg.type_plain   <= PLAIN_RESET;
            cfg_reg.type_packed  <= PACKED_RESET;
            cfg_reg.length_limit <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_START_MARKER: cfg_reg.start_marker <= pwdata[7:0];
                REG_END_MARKER:   cfg_reg.end_marker   <= pwdata[7:0];
                REG_TYPE_PLAIN:   cfg_reg.type_plain   <= pwdata[7:0];
                REG_TYPE_PACKED:  cfg_reg.type_packed  <= pwdata[7:0];
                REG_LENGTH_LIMIT: cfg_reg.length_limit <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_START_MARKER: prdata = {24'h0, cfg_reg.start_marker};
            REG_END_MARKER:   prdata = {24'h0, cfg_reg.end_marker};
            REG_TYPE_PLAIN:   prdata = {24'h0, cfg_reg.type_plain};
            REG_TYPE_PACKED:  prdata = {24'h0, cfg_reg.type_packed};
            REG_LENGTH_LIMIT: prdata = {16'h0, cfg_reg.length_limit};
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/plfd_front.sv -----
`default_nettype none

`include "printer_link_frame_deframer_defines.svh"

module plfd_front
    import plfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] rx_byte,
    input  wire cfg_t       cfg,
    output logic            res_valid,
    output rec_t            res
);

    fstate_t     state_reg, state_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  index_reg, index_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_inc;
    logic [15:0] len_full;
    logic        emit;

    assign count_inc = count_reg + 16'd1;
    assign len_full  = {rx_byte, len_reg[7:0]};

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        type_next  = type_reg;
        index_next = index_reg;
        len_next   = len_reg;
        emit       = 1'b0;
        res.kind    = EV_PAYLOAD;
        res.data    = rx_byte;
        res.offset  = count_reg;
        res.ftype   = type_reg;
        res.findex  = index_reg;
        res.flength = len_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rx_byte == cfg.start_marker)
                begin
                    state_next = ST_TYPE;
                    len_next   = 16'h0;
                end
            end
            ST_TYPE:
            begin
                type_next  = rx_byte;
                state_next = ST_INDEX;
            end
            ST_INDEX:
            begin
                index_next = rx_byte;
                state_next = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                len_next   = {8'h0, rx_byte};
                state_next = ST_LEN_HI;
            end
            ST_LEN_HI:
            begin
                len_next   = len_full;
                count_next = 16'h0;
                // bad length skips straight to the trailer
                if (len_full != 16'h0 && len_full < cfg.length_limit)
                    state_next = ST_PAYLOAD;
                else
                    state_next = ST_TRAILER;
            end
            ST_PAYLOAD:
            begin
                emit = 1'b1;
                if (count_inc >= len_reg)
                begin
                    count_next = 16'h0;
                    state_next = ST_TRAILER;
                end
                else
                    count_next = count_inc;
            end
            ST_TRAILER:
            begin
                if (count_inc >= TRAILER_BYTES)
                begin
                    emit       = (rx_byte == cfg.end_marker);
                    res.kind   = EV_FRAME;
                    res.data   = 8'h0;
                    res.offset = 16'h0;
                    count_next = 16'h0;
                    state_next = ST_IDLE;
                end
                else
                    count_next = count_inc;
            end
            default:
            begin
                state_next = ST_IDLE;
                count_next = 16'h0;
            end
        endcase
    end

    assign res_valid = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= 16'h0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg  <= type_next;
            index_reg <= index_next;
            len_reg   <= len_next;
        end
    end

    `PLFD_ASSERT_IMPL(a_payload_in_range, state_reg == ST_PAYLOAD, count_reg < len_reg,
        "payload count reached frame length")
    `PLFD_ASSERT_IMPL(a_trailer_in_range, state_reg == ST_TRAILER, count_reg < TRAILER_BYTES,
        "trailer count overran")
    `PLFD_ASSERT_IMPL(a_emit_phase, res_valid,
        state_reg == ST_PAYLOAD || state_reg == ST_TRAILER, "result outside payload or trailer")

endmodule

`default_nettype wire

// ----- rtl/core/plfd_queue.sv -----
`default_nettype none

`include "printer_link_frame_deframer_defines.svh"

module plfd_queue
    import plfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire rec_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output rec_t      rd_data,
    output logic      valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    `PLFD_ASSERT_IMPL(a_no_write_when_full, wr_en, !full, "write into a full queue")
    `PLFD_ASSERT_IMPL(a_count_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH), "queue count overflow")

endmodule

`default_nettype wire

// ----- rtl/core/plfd_back.sv -----
`default_nettype none

module plfd_back
    import plfd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic q_valid,
    input  wire rec_t q_data,
    output logic      q_pop,
    input  wire logic pop,
    output logic      empty,
    output logic        event_kind,
    output logic [7:0]  payload_byte,
    output logic [15:0] payload_offset,
    output logic        is_print_data,
    output logic [7:0]  frame_type,
    output logic [7:0]  frame_index,
    output logic [15:0] frame_length,
    output logic        length_ok
);

    logic out_valid_reg, out_valid_next;
    rec_t rec_reg;
    logic load;

    // refill whenever the output slot is free or being drained
    assign load           = !out_valid_reg || pop;
    assign q_pop          = q_valid && load;
    assign out_valid_next = load ? q_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            rec_reg <= q_data;
    end

    assign empty          = !out_valid_reg;
    assign event_kind     = rec_reg.kind;
    assign payload_byte   = rec_reg.data;
    assign payload_offset = rec_reg.offset;
    assign frame_type     = rec_reg.ftype;
    assign frame_index    = rec_reg.findex;
    assign frame_length   = rec_reg.flength;
    // flags use the live registers; the user must keep them put while results are pending, not enforced here
    assign is_print_data  = (rec_reg.ftype == cfg.type_plain) ||
                            (rec_reg.ftype == cfg.type_packed);
    assign length_ok      = (rec_reg.flength != 16'h0) &&
                            (rec_reg.flength < cfg.length_limit);

endmodule

`default_nettype wire

// ----- rtl/core/printer_link_frame_deframer.sv -----
// Printer link deframer: takes one received byte per clock unless full (push/full), hunts
// for the start byte, captures type, index and a little-endian 16-bit length, and returns
// one transaction per payload byte plus one for each frame whose last trailer byte matches
// the end byte (empty/pop). A byte can be accepted every cycle while full is low; the
// parser updates its state in the cycle the byte is taken and writes the result into the
// queue at that same edge; from there it moves into the output register, and so onto the
// result ports, once that register is free or being popped. Results wait in a
// QUEUE_DEPTH-entry queue plus one output register, and full is raised only once all of
// those hold results the reader has not popped. Configuration registers sit on an APB port
// at byte offsets 0x00 to 0x10 and should only be changed while no results are outstanding.
`default_nettype none

module printer_link_frame_deframer
    import plfd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        rx_byte,
    output logic                   empty,
    input  wire logic              pop,
    output logic                   event_kind,
    output logic [7:0]             payload_byte,
    output logic [15:0]            payload_offset,
    output logic                   is_print_data,
    output logic [7:0]             frame_type,
    output logic [7:0]             frame_index,
    output logic [15:0]            frame_length,
    output logic                   length_ok
);

    cfg_t cfg;
    logic accept;
    logic res_valid;
    rec_t res;
    logic q_valid;
    rec_t q_data;
    logic q_pop;

    assign accept = push && !full;

    plfd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    plfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    plfd_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .valid   (q_valid)
    );

    plfd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .event_kind     (event_kind),
        .payload_byte   (payload_byte),
        .payload_offset (payload_offset),
        .is_print_data  (is_print_data),
        .frame_type     (frame_type),
        .frame_index    (frame_index),
        .frame_length   (frame_length),
        .length_ok      (length_ok)
    );

endmodule

`default_nettype wire
